FILE: sv/call_frame_stack_manager_assert.svh
// Assertion macros for the checker file of the call-frame stack manager.
`ifndef CALL_FRAME_STACK_MANAGER_ASSERT_SVH
`define CALL_FRAME_STACK_MANAGER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFSM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/cfsm_pkg.sv
package cfsm_pkg;

	// Action codes of a command transaction.
	localparam logic [2:0] ACT_PUSH  = 3'd0;
	localparam logic [2:0] ACT_ALLOC = 3'd1;
	localparam logic [2:0] ACT_FREE  = 3'd2;
	localparam logic [2:0] ACT_GET   = 3'd3;
	localparam logic [2:0] ACT_SET   = 3'd4;
	localparam logic [2:0] ACT_BACK  = 3'd5;

	// Status codes of a result transaction.
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_INDEX = 3'd1;
	localparam logic [2:0] ST_ALLOC = 3'd2;
	localparam logic [2:0] ST_FREE  = 3'd3;
	localparam logic [2:0] ST_PUSH  = 3'd4;
	localparam logic [2:0] ST_EMPTY = 3'd5;

	// Width of one stored word.
	localparam int WORD_W = 32;

	typedef struct packed {
		logic [2:0]               action;
		logic [8:0]               amount;
		logic signed [WORD_W-1:0] value;
	} cfsm_cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_word;
		logic [2:0]               status;
		logic                     unfreed_warning;
	} cfsm_rsp_t;

endpackage

FILE: sv/cfsm_store.sv
module cfsm_store import cfsm_pkg::*; #(
	parameter int STORE_DEPTH = 256,
	localparam int AW = $clog2(STORE_DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr_a,
	input  logic [AW-1:0]     raddr_b,
	output logic [WORD_W-1:0] rdata_a,
	output logic [WORD_W-1:0] rdata_b
);

	logic [WORD_W-1:0] mem [STORE_DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Two registered read ports.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

FILE: sv/cfsm_exec.sv
module cfsm_exec import cfsm_pkg::*; #(
	parameter int STORE_DEPTH = 256,
	localparam int AW = $clog2(STORE_DEPTH),
	localparam int PW = $clog2(STORE_DEPTH + 1)
) (
	input  cfsm_cmd_t                cmd,
	input  logic [PW-1:0]            base,
	input  logic [PW-1:0]            top,
	input  logic signed [WORD_W-1:0] rd_a,
	input  logic signed [WORD_W-1:0] rd_b,
	output cfsm_rsp_t                rsp,
	output logic                     we,
	output logic [AW-1:0]            waddr,
	output logic [WORD_W-1:0]        wdata,
	output logic [PW-1:0]            base_nxt,
	output logic [PW-1:0]            top_nxt
);

	// Unsigned pointer sums and signed trailer arithmetic.
	localparam int SW = ((PW > 9) ? PW : 9) + 2;
	localparam int XW = WORD_W + 4;
	localparam logic [SW-1:0]        LIM_U = SW'(STORE_DEPTH);
	localparam logic signed [XW-1:0] LIM_S = XW'(STORE_DEPTH);
	localparam logic signed [XW-1:0] ONE_S = XW'(1);
	localparam logic signed [XW-1:0] TWO_S = XW'(2);

	logic [SW-1:0]        base_x, top_x, sum_n, sum_n1, sum_n2;
	logic                 alloc_fit, slot_fit;
	logic signed [XW-1:0] base_s, amt_s, held, keep, fsum, fsum1, fsum2, nb;
	logic                 free_fit, nb_bad;

	// Alloc and slot bounds against the store depth and the stack top.
	assign base_x    = SW'(base);
	assign top_x     = SW'(top);
	assign sum_n     = base_x + SW'(cmd.amount);
	assign sum_n1    = sum_n + SW'(1);
	assign sum_n2    = sum_n + SW'(2);
	assign alloc_fit = (sum_n2 <= LIM_U);
	assign slot_fit  = (sum_n2 <= top_x);

	// Free: locals held come from the trailer word just below the top.
	assign base_s   = signed'(XW'(base));
	assign amt_s    = signed'(XW'(cmd.amount));
	assign held     = (top > base) ? -XW'(rd_a) : '0;
	assign keep     = held - amt_s;
	assign fsum     = base_s + keep;
	assign fsum1    = fsum + ONE_S;
	assign fsum2    = fsum + TWO_S;
	assign free_fit = (fsum2 <= LIM_S);

	// Back: previous base from the trailer below the current base.
	assign nb     = base_s + XW'(rd_a) - TWO_S;
	assign nb_bad = (nb < 0) || (nb >= base_s);

	always_comb begin
		rsp.read_word       = '0;
		rsp.status          = ST_OK;
		rsp.unfreed_warning = 1'b0;
		we                  = 1'b0;
		waddr               = '0;
		wdata               = '0;
		base_nxt            = base;
		top_nxt             = top;
		case (cmd.action)
			ACT_PUSH: begin
				if (top_x < LIM_U) begin
					we       = 1'b1;
					waddr    = top[AW-1:0];
					wdata    = cmd.value;
					base_nxt = top;
				end else begin
					rsp.status = ST_PUSH;
				end
			end
			ACT_ALLOC: begin
				if (alloc_fit) begin
					we      = 1'b1;
					waddr   = sum_n1[AW-1:0];
					wdata   = WORD_W'(0) - WORD_W'(cmd.amount);
					top_nxt = sum_n2[PW-1:0];
				end else begin
					rsp.status = ST_ALLOC;
				end
			end
			ACT_FREE: begin
				if (keep == 0) begin
					top_nxt = base;
				end else if (keep > 0) begin
					if (free_fit) begin
						we      = 1'b1;
						waddr   = fsum1[AW-1:0];
						wdata   = WORD_W'(0) - keep[WORD_W-1:0];
						top_nxt = fsum2[PW-1:0];
					end else begin
						rsp.status = ST_ALLOC;
					end
				end else begin
					rsp.status = ST_FREE;
				end
			end
			ACT_GET: begin
				if (slot_fit) begin
					rsp.read_word = rd_a;
				end else begin
					rsp.status = ST_INDEX;
				end
			end
			ACT_SET: begin
				if (slot_fit) begin
					we    = 1'b1;
					waddr = sum_n[AW-1:0];
					wdata = cmd.value;
				end else begin
					rsp.status = ST_INDEX;
				end
			end
			ACT_BACK: begin
				if (base == '0) begin
					rsp.status = ST_EMPTY;
				end else begin
					rsp.unfreed_warning = (top != base);
					rsp.read_word       = rd_b;
					top_nxt             = base;
					base_nxt            = nb_bad ? '0 : nb[PW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: sv/call_frame_stack_manager.sv
// Channel   Handshake           Payload
// command   start / busy        cmd    (action, amount, value)
// result    done, one cycle     result (read_word, status, unfreed_warning)
//
// For every command the store is read at the accepting edge, and the execute
// state that follows computes, writes back and registers the result.
// The store's registered read ports set this order; a new command may be
// accepted in the cycle in which the result is shown.
// After reset a clearing pass zeroes the store, with busy high.
// The receiver cannot stall: done is high for exactly one cycle per command.
module call_frame_stack_manager import cfsm_pkg::*; #(
	parameter int STORE_DEPTH = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  cfsm_cmd_t cmd,
	output logic      done,
	output cfsm_rsp_t result
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int PW = $clog2(STORE_DEPTH + 1);
	localparam int SW = ((PW > 9) ? PW : 9) + 2;

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_q;
	logic [PW-1:0]     base_q, top_q;
	cfsm_cmd_t         cmd_s1;
	cfsm_rsp_t         result_q;
	logic              done_q;

	logic              accept;
	logic [AW-1:0]     raddr_a, raddr_b;
	logic [SW-1:0]     slot_sum;
	logic [WORD_W-1:0] rdata_a, rdata_b;
	logic              mem_we, ex_we;
	logic [AW-1:0]     mem_waddr, ex_waddr;
	logic [WORD_W-1:0] mem_wdata, ex_wdata;
	cfsm_rsp_t         ex_rsp;
	logic [PW-1:0]     ex_base, ex_top;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	// Read addresses are taken from the incoming command and the current pointers.
	assign slot_sum = SW'(base_q) + SW'(cmd.amount);
	assign raddr_b  = base_q[AW-1:0];
	always_comb begin
		case (cmd.action)
			ACT_FREE: raddr_a = AW'(top_q - PW'(1));
			ACT_GET:  raddr_a = slot_sum[AW-1:0];
			ACT_BACK: raddr_a = AW'(base_q - PW'(1));
			default:  raddr_a = '0;
		endcase
	end

	// The clearing pass owns the write port until it finishes.
	always_comb begin
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = ex_we && (state_q == S_EXEC);
			mem_waddr = ex_waddr;
			mem_wdata = ex_wdata;
		end
	end

	cfsm_store #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (accept),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	cfsm_exec #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_exec (
		.cmd      (cmd_s1),
		.base     (base_q),
		.top      (top_q),
		.rd_a     (rdata_a),
		.rd_b     (rdata_b),
		.rsp      (ex_rsp),
		.we       (ex_we),
		.waddr    (ex_waddr),
		.wdata    (ex_wdata),
		.base_nxt (ex_base),
		.top_nxt  (ex_top)
	);

	// Sequencer, pointers and clear counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			base_q  <= '0;
			top_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(STORE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					base_q  <= ex_base;
					top_q   <= ex_top;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command and result holding registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
		if (state_q == S_EXEC) begin
			result_q <= ex_rsp;
		end
	end

endmodule

FILE: sv/cfsm_checker.sv
`include "call_frame_stack_manager_assert.svh"

module cfsm_checker import cfsm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input cfsm_cmd_t cmd,
	input logic      done,
	input cfsm_rsp_t result
);

	logic accepted;

	assign accepted = start && !busy;

	// Each accepted transaction is answered by the done strobe that follows its execute state, with busy high in between.
	`CFSM_ASSERT_NEXT(a_answer, clk, arst_n, accepted, busy && !done, "no busy after accept")
	`CFSM_ASSERT_NEXT(a_done, clk, arst_n, accepted, ##1 done, "result strobe missing")
	`CFSM_ASSERT_NOW(a_ready, clk, arst_n, done, !busy && $past(busy), "strobe out of sequence")

	// Failed commands return no data and no warning.
	`CFSM_ASSERT_NOW(a_err_zero, clk, arst_n, done && (result.status != ST_OK),
		(result.read_word == 0) && !result.unfreed_warning, "error with data")

endmodule

bind call_frame_stack_manager cfsm_checker u_cfsm_checker (.*);
